>>> rtl/tiad_pkg.sv
// ============================================================================
// tiad_pkg: shared types and constants for the time index block
// Holds the command word passed from the front end to the back end, the queue
// status group, the back-end state type and the result status codes.
// ============================================================================
`default_nettype none

package tiad_pkg;

    localparam int TIME_W      = 64;
    localparam int OFFSET_W    = 63;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    // Thinning threshold: j * span / half depth stays below three spans
    localparam int THR_W = TIME_W + 2;

    // Command queue between front and back (power of two, pointers wrap)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_THINNED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HALVED   = 2'd3;

    typedef struct packed {
        logic                is_reject;
        logic [TIME_W-1:0]   entry_time;
        logic [OFFSET_W-1:0] entry_offset;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_THIN,
        BK_HALVE,
        BK_APPEND
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/tiad_front.sv
// ============================================================================
// tiad_front: word intake and classification
// Accepts one word per cycle while the queue has room, flags it as rejected
// when its time does not exceed the last appended time, and queues it.
// ============================================================================
`default_nettype none

module tiad_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  tiad_pkg::q_stat_t                      qs,
    input  logic signed [tiad_pkg::TIME_W-1:0]     entry_time,
    input  logic        [tiad_pkg::OFFSET_W-1:0]   entry_offset,
    output logic                                   push,
    output tiad_pkg::cmd_t                         cmd
);
    import tiad_pkg::*;

    logic                     has_entry_reg;
    logic                     has_entry_next;
    logic signed [TIME_W-1:0] last_time_reg;
    logic signed [TIME_W-1:0] last_time_next;
    logic                     is_reject;

    assign push      = start && !qs.full;
    assign is_reject = has_entry_reg && (last_time_reg >= entry_time);

    assign cmd.is_reject    = is_reject;
    assign cmd.entry_time   = $unsigned(entry_time);
    assign cmd.entry_offset = entry_offset;

    always_comb
    begin
        has_entry_next = has_entry_reg;
        last_time_next = last_time_reg;
        // Track the newest accepted time; a rejected word leaves it alone
        if (push && !is_reject)
        begin
            has_entry_next = 1'b1;
            last_time_next = entry_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_entry_reg <= 1'b0;
        end
        else
        begin
            has_entry_reg <= has_entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_time_reg <= last_time_next;
    end

endmodule

`default_nettype wire

>>> rtl/tiad_queue.sv
// ============================================================================
// tiad_queue: short command queue
// Decouples the intake from the table sequencer so each side stalls alone.
// ============================================================================
`default_nettype none

module tiad_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tiad_pkg::cmd_t    cmd_in,
    input  logic              pop,
    output tiad_pkg::cmd_t    head,
    output tiad_pkg::q_stat_t qs
);
    import tiad_pkg::*;

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg;
    logic [QFILL_W-1:0] fill_next;

    assign head     = slot_reg[rd_ptr_reg];
    assign qs.full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign qs.empty = (fill_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tiad_div.sv
// ============================================================================
// tiad_div: span split by half the table depth
// Half the depth is a power of two, so the quotient is a shift and the
// remainder a mask; both are registered and ready in the cycle after start.
// ============================================================================
`default_nettype none

module tiad_div #(
    parameter  int TABLE_DEPTH = 1024,
    localparam int HALF        = TABLE_DEPTH / 2,
    localparam int RW          = $clog2(HALF) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tiad_pkg::TIME_W-1:0]   dividend,
    output logic [tiad_pkg::TIME_W-1:0]   quotient,
    output logic [RW-1:0]                 remainder,
    output logic                          done
);
    import tiad_pkg::*;

    localparam int SH = $clog2(HALF);

    logic              done_reg;
    logic              done_next;
    logic [TIME_W-1:0] quo_reg;
    logic [TIME_W-1:0] quo_next;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     rem_next;

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    // Drop the low bits into the remainder, shift the rest down
    assign done_next = start;
    assign quo_next  = start ? (dividend >> SH) : quo_reg;
    assign rem_next  = start ? RW'(dividend[SH-1:0]) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

>>> rtl/tiad_back.sv
// ============================================================================
// tiad_back: table sequencer
// Pops queued words, reports rejections, appends to the time and offset
// memories, and on a full table thins it, halving it if over 3/4 survive.
// ============================================================================
`default_nettype none

module tiad_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tiad_pkg::q_stat_t                   qs,
    input  tiad_pkg::cmd_t                      head,
    output logic                                pop,
    output logic                                done,
    output logic [tiad_pkg::STATUS_W-1:0]       status,
    output logic [tiad_pkg::COUNT_OUT_W-1:0]    entry_count
);
    import tiad_pkg::*;

    localparam int HALF        = TABLE_DEPTH / 2;
    localparam int HALVE_LIMIT = 3 * TABLE_DEPTH / 4;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int RW          = $clog2(HALF) + 1;

    back_state_t state_reg;
    back_state_t state_next;

    // Table memories
    logic [TIME_W-1:0]   time_mem   [TABLE_DEPTH];
    logic [OFFSET_W-1:0] offset_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]   rd_time_reg;
    logic [OFFSET_W-1:0] rd_off_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [TIME_W-1:0]   wtime;
    logic [OFFSET_W-1:0] woff;
    logic [AW-1:0]       raddr;

    // Table bookkeeping
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [TIME_W-1:0] base_reg;
    logic [TIME_W-1:0] base_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;

    // Sweep state
    logic [THR_W-1:0]    thr_reg;
    logic [THR_W-1:0]    thr_next;
    logic [RW-1:0]       acc_reg;
    logic [RW-1:0]       acc_next;
    logic [CW-1:0]       keep_cnt_reg;
    logic [CW-1:0]       keep_cnt_next;
    logic [CW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       rd_ptr_next;
    logic [CW-1:0]       wr_ptr_reg;
    logic [CW-1:0]       wr_ptr_next;
    logic                s1_vld_reg;
    logic                s1_vld_next;
    logic                s2_vld_reg;
    logic                s2_vld_next;
    logic [TIME_W-1:0]   rel_reg;
    logic [TIME_W-1:0]   s2_time_reg;
    logic [OFFSET_W-1:0] s2_off_reg;
    logic                halved_reg;
    logic                halved_next;

    // Result register
    logic                done_reg;
    logic                done_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [CW-1:0]       cnt_out_reg;
    logic [CW-1:0]       cnt_out_next;

    // Divider
    logic                div_start;
    logic [TIME_W-1:0]   span;
    logic [TIME_W-1:0]   div_q;
    logic [RW-1:0]       div_r;
    logic                div_done;

    logic              count_full;
    logic              issue;
    logic              thin_end;
    logic              halve_end;
    logic              keep;
    logic [RW-1:0]     frac_sum;
    logic              carry;
    logic [CW:0]       hv_addr;

    assign span       = last_reg - base_reg;
    assign count_full = (count_reg == CW'(TABLE_DEPTH));
    assign issue      = (rd_ptr_reg < count_reg);
    assign thin_end   = !issue && !s1_vld_reg && !s2_vld_reg;
    assign halve_end  = !issue && !s1_vld_reg;
    assign keep       = (THR_W'(rel_reg) >= thr_reg);
    assign frac_sum   = acc_reg + div_r;
    assign carry      = (frac_sum >= RW'(HALF));
    assign hv_addr    = {rd_ptr_reg, 1'b0};

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_OUT_W'(cnt_out_reg);

    tiad_div #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (span),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qs.empty && !head.is_reject && count_full)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_THIN;
                end
            end
            BK_THIN:
            begin
                if (thin_end)
                begin
                    state_next = (keep_cnt_reg > CW'(HALVE_LIMIT)) ? BK_HALVE : BK_APPEND;
                end
            end
            BK_HALVE:
            begin
                if (halve_end)
                begin
                    state_next = BK_APPEND;
                end
            end
            BK_APPEND:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        we            = 1'b0;
        waddr         = count_reg[AW-1:0];
        wtime         = head.entry_time;
        woff          = head.entry_offset;
        raddr         = rd_ptr_reg[AW-1:0];
        div_start     = 1'b0;
        count_next    = count_reg;
        base_next     = base_reg;
        last_next     = last_reg;
        cmd_next      = cmd_reg;
        thr_next      = thr_reg;
        acc_next      = acc_reg;
        keep_cnt_next = keep_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        s1_vld_next   = 1'b0;
        s2_vld_next   = 1'b0;
        halved_next   = halved_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        cnt_out_next  = cnt_out_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qs.empty)
                begin
                    pop = 1'b1;
                    if (head.is_reject)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_REJECTED;
                        cnt_out_next = count_reg;
                    end
                    else if (count_full)
                    begin
                        // Park the word and size the thinning marks first
                        cmd_next  = head;
                        div_start = 1'b1;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            base_next = head.entry_time;
                        end
                        last_next    = head.entry_time;
                        done_next    = 1'b1;
                        status_next  = ST_APPENDED;
                        cnt_out_next = count_reg + 1'b1;
                    end
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    // Mark for one kept entry: floor(span / half depth)
                    thr_next      = THR_W'(div_q);
                    acc_next      = div_r;
                    keep_cnt_next = CW'(1);
                    rd_ptr_next   = CW'(1);
                    halved_next   = 1'b0;
                end
            end
            BK_THIN:
            begin
                s1_vld_next = issue;
                s2_vld_next = s1_vld_reg;
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (s2_vld_reg && keep)
                begin
                    we            = 1'b1;
                    waddr         = keep_cnt_reg[AW-1:0];
                    wtime         = s2_time_reg;
                    woff          = s2_off_reg;
                    keep_cnt_next = keep_cnt_reg + 1'b1;
                    // Advance the mark by span / half depth, carrying the fraction
                    thr_next      = thr_reg + THR_W'(div_q) + THR_W'(carry);
                    acc_next      = carry ? (frac_sum - RW'(HALF)) : frac_sum;
                end
                if (thin_end)
                begin
                    if (keep_cnt_reg > CW'(HALVE_LIMIT))
                    begin
                        count_next  = keep_cnt_reg >> 1;
                        halved_next = 1'b1;
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                    end
                    else
                    begin
                        count_next = keep_cnt_reg;
                    end
                end
            end
            BK_HALVE:
            begin
                // Keep the even positions: read 2k, write k
                raddr       = hv_addr[AW-1:0];
                s1_vld_next = issue;
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (s1_vld_reg)
                begin
                    we          = 1'b1;
                    waddr       = wr_ptr_reg[AW-1:0];
                    wtime       = rd_time_reg;
                    woff        = rd_off_reg;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
            end
            BK_APPEND:
            begin
                we           = 1'b1;
                waddr        = count_reg[AW-1:0];
                wtime        = cmd_reg.entry_time;
                woff         = cmd_reg.entry_offset;
                count_next   = count_reg + 1'b1;
                last_next    = cmd_reg.entry_time;
                done_next    = 1'b1;
                status_next  = halved_reg ? ST_HALVED : ST_THINNED;
                cnt_out_next = count_reg + 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            halved_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            halved_reg <= halved_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        last_reg     <= last_next;
        cmd_reg      <= cmd_next;
        thr_reg      <= thr_next;
        acc_reg      <= acc_next;
        keep_cnt_reg <= keep_cnt_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        rel_reg      <= rd_time_reg - base_reg;
        s2_time_reg  <= rd_time_reg;
        s2_off_reg   <= rd_off_reg;
        status_reg   <= status_next;
        cnt_out_reg  <= cnt_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            time_mem[waddr]   <= wtime;
            offset_mem[waddr] <= woff;
        end
        rd_time_reg <= time_mem[raddr];
        rd_off_reg  <= offset_mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/time_index_append_decimate.sv
// ============================================================================
// time_index_append_decimate: seek index of strictly increasing time points
// Keeps (time, offset) pairs in on-chip memory and thins the table when full.
// ============================================================================
// Usage
//   Input: drive entry_time and entry_offset with start high; the word is
//   taken at a rising edge where start is high and busy is low. busy rises
//   when the two-word command queue is full.
//   Output: one result per word. done is high for exactly one cycle with
//   status and entry_count valid; the receiver must take it then.
//   An append or a rejection passes through the queue and then the done
//   register before it is reported; back-to-back words of that kind run at one per cycle.
//   A word arriving on a full table first triggers a rebuild: the span is
//   split by half the depth (a shift and a mask, so the depth must
//   be a power of two), then a thinning sweep runs, then, when over
//   three quarters survive, a halving sweep, and last the append. The
//   memory read port paces both sweeps at one entry a cycle; the queue
//   takes up to two more words meanwhile, then busy holds the source.
//   Reset: the table is emptied (count to zero), the queue is flushed and no
//   result is pending. Memory contents are not cleared; only entries below
//   the count are ever read.
// ============================================================================
`default_nettype none

module time_index_append_decimate #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [tiad_pkg::TIME_W-1:0]     entry_time,
    input  logic        [tiad_pkg::OFFSET_W-1:0]   entry_offset,
    output logic                                   done,
    output logic        [tiad_pkg::STATUS_W-1:0]   status,
    output logic        [tiad_pkg::COUNT_OUT_W-1:0] entry_count
);
    import tiad_pkg::*;

    localparam int HALVE_LIMIT = 3 * TABLE_DEPTH / 4;

    logic    push;
    logic    pop;
    cmd_t    front_cmd;
    cmd_t    head;
    q_stat_t qs;

    // Hold off the source only while the queue has no free slot
    assign busy = qs.full;

    // Front: classify each word against the newest accepted time
    tiad_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .qs           (qs),
        .entry_time   (entry_time),
        .entry_offset (entry_offset),
        .push         (push),
        .cmd          (front_cmd)
    );

    // Queue: lets the intake carry on while the back end rebuilds the table
    tiad_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (front_cmd),
        .pop    (pop),
        .head   (head),
        .qs     (qs)
    );

    // Back: append, thin and halve, then report
    tiad_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qs          (qs),
        .head        (head),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .entry_count (entry_count)
    );

    // A taken word must be waiting in the queue on the following cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !qs.empty)
        else $error("accepted word missing from the queue");

    // After a rebuild no more than three quarters of the table plus one remain
    a_thin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((TABLE_DEPTH <= 1024) && done && (status == ST_THINNED || status == ST_HALVED))
        |-> (entry_count <= COUNT_OUT_W'(HALVE_LIMIT + 1)))
        else $error("table count too high after thinning");

    // A rejection needs an earlier entry, so the table cannot be empty
    a_reject_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((TABLE_DEPTH <= 1024) && done && (status == ST_REJECTED))
        |-> (entry_count != '0))
        else $error("rejection reported on an empty table");

endmodule

`default_nettype wire
